/* hdl/hrf_pkg.sv */
`default_nettype none

package hrf_pkg;

    localparam int LENGTH_BITS = 63;
    localparam int MAG_W       = LENGTH_BITS + 1;
    localparam int SUM_W       = MAG_W + 4;
    localparam int BODY_LEN_W  = 63;
    localparam int PAT_LEN     = 15;
    localparam int POS_W       = 4;

    localparam logic [SUM_W-1:0] LIMIT_POS = {{(SUM_W-LENGTH_BITS){1'b0}}, {LENGTH_BITS{1'b1}}};
    localparam logic [SUM_W-1:0] LIMIT_NEG = LIMIT_POS + SUM_W'(1);

    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic [2:0] TAG_METHOD  = 3'd0;
    localparam logic [2:0] TAG_PATH    = 3'd1;
    localparam logic [2:0] TAG_VERSION = 3'd2;
    localparam logic [2:0] TAG_DELIM   = 3'd3;
    localparam logic [2:0] TAG_HEADER  = 3'd4;
    localparam logic [2:0] TAG_BODY    = 3'd5;

    localparam logic [1:0] ERR_NONE   = 2'd0;
    localparam logic [1:0] ERR_LINE   = 2'd1;
    localparam logic [1:0] ERR_LENGTH = 2'd2;

    typedef struct packed {
        logic step;
        logic clear;
    } t_len_ctl;

    typedef struct packed {
        logic                   negative;
        logic                   nonzero;
        logic [LENGTH_BITS-1:0] value;
    } t_len_info;

    typedef struct packed {
        logic [POS_W-1:0] pos;
        logic             match;
    } t_pat_res;

    // "Content-Length:" or "content-length:"
    function automatic logic [7:0] pat_byte(input logic lower, input logic [POS_W-1:0] pos);
        logic [7:0] c;
        case (pos)
            4'd0:    c = lower ? "c" : "C";
            4'd1:    c = "o";
            4'd2:    c = "n";
            4'd3:    c = "t";
            4'd4:    c = "e";
            4'd5:    c = "n";
            4'd6:    c = "t";
            4'd7:    c = "-";
            4'd8:    c = lower ? "l" : "L";
            4'd9:    c = "e";
            4'd10:   c = "n";
            4'd11:   c = "g";
            4'd12:   c = "t";
            4'd13:   c = "h";
            4'd14:   c = ":";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic t_pat_res pat_step(input logic lower, input logic [POS_W-1:0] pos,
                                          input logic [7:0] b);
        t_pat_res         res;
        logic [POS_W-1:0] p;
        p = (pos >= POS_W'(PAT_LEN)) ? '0 : pos;
        if (b == pat_byte(lower, p)) begin
            p = p + POS_W'(1);
        end else if (b == pat_byte(lower, '0)) begin
            p = POS_W'(1);
        end else begin
            p = '0;
        end
        res.match = (p == POS_W'(PAT_LEN));
        res.pos   = res.match ? '0 : p;
        return res;
    endfunction

endpackage

`default_nettype wire

/* hdl/hrf_len_parser.sv */
`default_nettype none

module hrf_len_parser
    import hrf_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_len_ctl   i_ctl,
    input  wire logic [7:0] i_byte,
    output t_len_info       o_len
);

    typedef enum logic [3:0] {
        PP_IDLE  = 4'b0001,
        PP_BLANK = 4'b0010,
        PP_MINUS = 4'b0100,
        PP_DIGIT = 4'b1000
    } t_pphase;

    t_pphase          r_pphase, n_pphase;
    logic [MAG_W-1:0] r_mag, n_mag;
    logic             r_neg, n_neg;
    logic             r_ovf, n_ovf;
    logic [POS_W-1:0] r_up_pos, n_up_pos;
    logic [POS_W-1:0] r_lo_pos, n_lo_pos;
    logic             r_up_found, n_up_found;
    logic             r_lo_found, n_lo_found;

    logic             is_digit;
    logic             is_blank;
    logic [3:0]       digit_wide;
    logic [SUM_W-1:0] sum;
    logic             over;
    t_pat_res         up_res;
    t_pat_res         lo_res;

    assign is_digit   = (i_byte >= CH_ZERO) && (i_byte <= CH_NINE);
    assign is_blank   = (i_byte == CH_SP) || (i_byte == CH_TAB);
    assign digit_wide = 4'(i_byte - CH_ZERO);
    // value * 10 + digit
    assign sum  = SUM_W'({r_mag, 3'b000}) + SUM_W'({r_mag, 1'b0}) + SUM_W'(digit_wide);
    assign over = r_neg ? (sum > LIMIT_NEG) : (sum > LIMIT_POS);
    assign up_res = pat_step(1'b0, r_up_pos, i_byte);
    assign lo_res = pat_step(1'b1, r_lo_pos, i_byte);

    always_comb begin
        n_pphase   = r_pphase;
        n_mag      = r_mag;
        n_neg      = r_neg;
        n_ovf      = r_ovf;
        n_up_pos   = r_up_pos;
        n_lo_pos   = r_lo_pos;
        n_up_found = r_up_found;
        n_lo_found = r_lo_found;

        if (r_pphase != PP_IDLE) begin
            priority if (r_pphase == PP_BLANK && is_blank) begin
                n_pphase = r_pphase;
            end else if (r_pphase == PP_BLANK && i_byte == CH_MINUS) begin
                n_neg    = 1'b1;
                n_pphase = PP_MINUS;
            end else if (!is_digit) begin
                // value ends: no digits or overflow reads as zero
                if (!(r_pphase == PP_DIGIT && !r_ovf)) begin
                    n_mag = '0;
                end
                n_ovf    = 1'b0;
                n_pphase = PP_IDLE;
            end else begin
                n_pphase = PP_DIGIT;
                if (!r_ovf) begin
                    if (over) begin
                        n_ovf = 1'b1;
                    end else begin
                        n_mag = sum[MAG_W-1:0];
                    end
                end
            end
        end

        if (!r_up_found) begin
            n_up_pos = up_res.pos;
            if (up_res.match) begin
                n_up_found = 1'b1;
                n_mag      = '0;
                n_neg      = 1'b0;
                n_ovf      = 1'b0;
                n_pphase   = PP_BLANK;
            end
        end

        if (!n_up_found && !r_lo_found) begin
            n_lo_pos = lo_res.pos;
            if (lo_res.match) begin
                n_lo_found = 1'b1;
                n_mag      = '0;
                n_neg      = 1'b0;
                n_ovf      = 1'b0;
                n_pphase   = PP_BLANK;
            end
        end
    end

    assign o_len.nonzero  = |n_mag;
    assign o_len.negative = n_neg && (|n_mag);
    assign o_len.value    = n_mag[LENGTH_BITS-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clear) begin
            r_pphase   <= PP_IDLE;
            r_mag      <= '0;
            r_neg      <= 1'b0;
            r_ovf      <= 1'b0;
            r_up_pos   <= '0;
            r_lo_pos   <= '0;
            r_up_found <= 1'b0;
            r_lo_found <= 1'b0;
        end else if (i_ctl.step) begin
            r_pphase   <= n_pphase;
            r_mag      <= n_mag;
            r_neg      <= n_neg;
            r_ovf      <= n_ovf;
            r_up_pos   <= n_up_pos;
            r_lo_pos   <= n_lo_pos;
            r_up_found <= n_up_found;
            r_lo_found <= n_lo_found;
        end
    end

    a_digit_not_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pphase == PP_IDLE) |-> !r_ovf)
        else $error("overflow flag set outside a value");

    a_found_has_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_up_found && !r_lo_found) |-> (r_mag == '0 && r_pphase == PP_IDLE))
        else $error("value parsed before any length header");

    a_lower_after_upper: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_up_found && i_ctl.step && !i_ctl.clear) |=> $stable(r_lo_found) && $stable(r_lo_pos))
        else $error("lower-case match advanced after upper-case match");

endmodule

`default_nettype wire

/* hdl/http_request_framer.sv */
// http_request_framer
// Tags each byte of a request stream as method, path, version, delimiter,
// header or body, and marks the byte that ends or fails a request.
// Input channel: i_valid / o_ready with i_data_byte, one byte per item.
// Output channel: o_valid / i_ready with o_byte_out, o_field_tag,
// o_message_end, o_error_code and o_body_length, one result per input item.
// Path: an accepted item waits in the input register and moves into the
// output register once that is free; o_valid is high while it holds a result.
// Throughput: one byte per cycle while results are taken; framing state,
// header pattern matchers and the length accumulate (value times ten plus
// digit) all update combinationally between input and output register.
// When the receiver stalls, the waiting result holds and one more byte can sit
// in the input register; o_ready drops only when both are full.
// o_error_code and o_body_length are nonzero only on a byte with
// o_message_end; after such a byte the framer starts a new request.
// Reset (i_rst_n low at a clock edge) empties both registers and returns the
// framer to the start of a request line.
`default_nettype none

module http_request_framer
    import hrf_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_ready,
    input  wire logic [7:0]            i_data_byte,
    output logic                       o_valid,
    input  wire logic                  i_ready,
    output logic [7:0]                 o_byte_out,
    output logic [2:0]                 o_field_tag,
    output logic                       o_message_end,
    output logic [1:0]                 o_error_code,
    output logic [BODY_LEN_W-1:0]      o_body_length
);

    typedef enum logic [4:0] {
        PH_METHOD  = 5'b00001,
        PH_PATH    = 5'b00010,
        PH_VERSION = 5'b00100,
        PH_HEADER  = 5'b01000,
        PH_BODY    = 5'b10000
    } t_phase;

    typedef enum logic [3:0] {
        TM_IDLE   = 4'b0001,
        TM_CR     = 4'b0010,
        TM_CRLF   = 4'b0100,
        TM_CRLFCR = 4'b1000
    } t_term;

    logic                   r_in_valid;
    logic [7:0]             r_in_byte;
    logic                   r_out_valid;
    logic [7:0]             r_out_byte;
    logic [2:0]             r_out_tag;
    logic                   r_out_end;
    logic [1:0]             r_out_err;
    logic [LENGTH_BITS-1:0] r_out_len;

    t_phase                 r_phase, n_phase;
    t_term                  r_term, n_term;
    logic                   r_line_ok, n_line_ok;
    logic [LENGTH_BITS-1:0] r_remain, n_remain;
    logic [LENGTH_BITS-1:0] r_body_len, n_body_len;

    logic                   advance;
    logic                   done;
    logic                   end_now;
    logic [2:0]             tag;
    logic [1:0]             err;
    logic [LENGTH_BITS-1:0] blen;
    t_len_ctl               len_ctl;
    t_len_info              len_info;

    assign advance = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || advance;

    assign len_ctl.step  = advance && (r_phase != PH_BODY);
    assign len_ctl.clear = advance && done;

    hrf_len_parser u_len_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (len_ctl),
        .i_byte  (r_in_byte),
        .o_len   (len_info)
    );

    always_comb begin
        n_phase    = r_phase;
        n_term     = r_term;
        n_line_ok  = r_line_ok;
        n_remain   = r_remain;
        n_body_len = r_body_len;
        tag        = TAG_HEADER;
        err        = ERR_NONE;
        blen       = '0;
        end_now    = 1'b0;
        done       = 1'b0;

        if (r_phase == PH_BODY) begin
            tag      = TAG_BODY;
            n_remain = r_remain - LENGTH_BITS'(1);
            if (r_remain <= LENGTH_BITS'(1)) begin
                end_now  = 1'b1;
                blen     = r_body_len;
                n_phase  = PH_METHOD;
                n_remain = '0;
            end
        end else begin
            priority if (r_in_byte == CH_CR) begin
                n_term = (r_term == TM_CRLF) ? TM_CRLFCR : TM_CR;
            end else if (r_in_byte == CH_LF && r_term == TM_CR) begin
                n_term = TM_CRLF;
            end else if (r_in_byte == CH_LF && r_term == TM_CRLFCR) begin
                n_term = TM_IDLE;
                done   = 1'b1;
            end else begin
                n_term = TM_IDLE;
            end

            if (r_in_byte == CH_CR || r_in_byte == CH_LF) begin
                tag = TAG_DELIM;
                // first CR LF closes the request line
                if (r_in_byte == CH_LF && r_term == TM_CR && r_phase != PH_HEADER) begin
                    n_phase = PH_HEADER;
                end
            end else begin
                unique case (r_phase)
                    PH_METHOD: begin
                        tag = TAG_METHOD;
                        if (r_in_byte == CH_SP) begin
                            tag     = TAG_DELIM;
                            n_phase = PH_PATH;
                        end
                    end
                    PH_PATH: begin
                        tag = TAG_PATH;
                        if (r_in_byte == CH_SP) begin
                            tag       = TAG_DELIM;
                            n_phase   = PH_VERSION;
                            n_line_ok = 1'b1;
                        end
                    end
                    PH_VERSION: begin
                        tag = TAG_VERSION;
                    end
                    default: begin
                        tag = TAG_HEADER;
                    end
                endcase
            end

            if (done) begin
                if (!r_line_ok) begin
                    err = ERR_LINE;
                end else if (len_info.negative) begin
                    err = ERR_LENGTH;
                end
                n_term    = TM_IDLE;
                n_line_ok = 1'b0;
                if (err != ERR_NONE || !len_info.nonzero) begin
                    end_now = 1'b1;
                    n_phase = PH_METHOD;
                end else begin
                    n_phase    = PH_BODY;
                    n_remain   = len_info.value;
                    n_body_len = len_info.value;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_phase     <= PH_METHOD;
            r_term      <= TM_IDLE;
            r_line_ok   <= 1'b0;
            r_remain    <= '0;
            r_body_len  <= '0;
        end else begin
            if (o_ready) begin
                r_in_valid <= i_valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_phase     <= n_phase;
                r_term      <= n_term;
                r_line_ok   <= n_line_ok;
                r_remain    <= n_remain;
                r_body_len  <= n_body_len;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_byte <= i_data_byte;
        end
        if (advance) begin
            r_out_byte <= r_in_byte;
            r_out_tag  <= tag;
            r_out_end  <= end_now;
            r_out_err  <= err;
            r_out_len  <= blen;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_byte_out    = r_out_byte;
    assign o_field_tag   = r_out_tag;
    assign o_message_end = r_out_end;
    assign o_error_code  = r_out_err;
    assign o_body_length = BODY_LEN_W'(r_out_len);

    a_quiet_mid_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_message_end) |-> (o_error_code == ERR_NONE && o_body_length == '0))
        else $error("error or length reported before message end");

    a_body_count_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_BODY) |-> (r_remain != '0))
        else $error("body phase with nothing left to count");

    a_body_no_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_field_tag == TAG_BODY) |-> (o_error_code == ERR_NONE))
        else $error("error reported on a body byte");

    a_restart_after_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && end_now) |=> (r_phase == PH_METHOD && r_term == TM_IDLE && !r_line_ok))
        else $error("framer did not restart after message end");

endmodule

`default_nettype wire

/* sim/http_request_framer_tb.sv */
module http_request_framer_tb;
    import hrf_pkg::*;

    localparam int RANDOM_ITEMS = 1000;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DIR_ROWS     = 26;

    typedef enum logic [2:0] {FR_METHOD, FR_PATH, FR_VERSION, FR_HEADER, FR_BODY} t_framer_phase;
    typedef enum logic [1:0] {LV_IDLE, LV_BLANKS, LV_SIGN, LV_DIGITS} t_length_parse;

    typedef struct packed {
        logic [7:0]            data;
        logic [2:0]            tag;
        logic                  fin;
        logic [1:0]            err;
        logic [BODY_LEN_W-1:0] len;
    } t_framed_byte;

    typedef struct packed {
        logic         known;
        t_framed_byte want;
    } t_stim_row;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_valid     = 1'b0;
    logic [7:0]            i_data_byte = 8'h00;
    logic                  i_ready     = 1'b1;
    logic                  o_ready;
    logic                  o_valid;
    logic [7:0]            o_byte_out;
    logic [2:0]            o_field_tag;
    logic                  o_message_end;
    logic [1:0]            o_error_code;
    logic [BODY_LEN_W-1:0] o_body_length;

    http_request_framer DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_data_byte   (i_data_byte),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_byte_out    (o_byte_out),
        .o_field_tag   (o_field_tag),
        .o_message_end (o_message_end),
        .o_error_code  (o_error_code),
        .o_body_length (o_body_length)
    );

    always #5 i_clk = ~i_clk;

    // framer state as the predictor sees it
    t_framer_phase fr_phase;
    logic [1:0]    crlf_seen;
    logic [1:0]    spaces;
    int            up_pos;
    int            lo_pos;
    bit            up_hit;
    bit            lo_hit;
    logic [63:0]   up_val;
    logic [63:0]   lo_val;
    t_length_parse val_state;
    bit            val_upper;
    bit            val_neg;
    bit            val_ovf;
    logic [63:0]   body_left;

    string upper_name = "Content-Length:";
    string lower_name = "content-length:";

    t_framed_byte framed_q[$];
    t_framed_byte checked_item;
    t_stim_row    dir_rows[DIR_ROWS];
    logic [7:0]   req_bytes[$];

    int  mismatches    = 0;
    int  bytes_sent    = 0;
    int  burst_left    = 0;
    int  requests_done = 0;
    int  line_errors   = 0;
    int  length_errors = 0;
    int  body_bytes    = 0;
    int  cycle_count   = 0;
    int  ready_mode    = 0;
    int  ready_window  = 0;
    bit  drained_once  = 1'b0;

    function automatic void clear_framer();
        fr_phase  = FR_METHOD;
        crlf_seen = 2'd0;
        spaces    = 2'd0;
        up_pos    = 0;
        lo_pos    = 0;
        up_hit    = 1'b0;
        lo_hit    = 1'b0;
        up_val    = 64'd0;
        lo_val    = 64'd0;
        val_state = LV_IDLE;
        val_upper = 1'b0;
        val_neg   = 1'b0;
        val_ovf   = 1'b0;
        body_left = 64'd0;
    endfunction

    function automatic void begin_value(input bit upper);
        val_upper = upper;
        if (upper) begin
            up_val = 64'd0;
        end else begin
            lo_val = 64'd0;
        end
        val_state = LV_BLANKS;
        val_neg   = 1'b0;
        val_ovf   = 1'b0;
    endfunction

    function automatic void finish_value();
        logic [63:0] mag;
        logic [63:0] v;
        mag = val_upper ? up_val : lo_val;
        v   = 64'd0;
        if (val_state == LV_DIGITS && !val_ovf) begin
            v = val_neg ? 64'd0 - mag : mag;
        end
        if (val_upper) begin
            up_val = v;
        end else begin
            lo_val = v;
        end
        val_state = LV_IDLE;
        val_neg   = 1'b0;
        val_ovf   = 1'b0;
    endfunction

    // decimal accumulate with a range check against 2^LENGTH_BITS - 1, or 2^LENGTH_BITS when negative
    function automatic void value_byte(input logic [7:0] b);
        logic [63:0] acc;
        logic [63:0] lim;
        logic [63:0] d;
        acc = val_upper ? up_val : lo_val;
        if (val_state != LV_IDLE
                && !(val_state == LV_BLANKS && (b == CH_SP || b == CH_TAB))) begin
            if (val_state == LV_BLANKS && b == CH_MINUS) begin
                val_neg   = 1'b1;
                val_state = LV_SIGN;
            end else if (b < CH_ZERO || b > CH_NINE) begin
                finish_value();
            end else begin
                val_state = LV_DIGITS;
                if (!val_ovf) begin
                    d   = 64'(b - CH_ZERO);
                    lim = (64'd1 << LENGTH_BITS) - 64'd1 + (val_neg ? 64'd1 : 64'd0);
                    if (acc > (lim - d) / 64'd10) begin
                        val_ovf = 1'b1;
                    end else if (val_upper) begin
                        up_val = acc * 64'd10 + d;
                    end else begin
                        lo_val = acc * 64'd10 + d;
                    end
                end
            end
        end
    endfunction

    function automatic int pattern_next(input string pat, input int pos, input logic [7:0] b);
        int p;
        p = (pos >= PAT_LEN) ? 0 : pos;
        if (b == pat[p]) begin
            p++;
        end else if (b == pat[0]) begin
            p = 1;
        end else begin
            p = 0;
        end
        return p;
    endfunction

    function automatic t_framed_byte frame_byte(input logic [7:0] b);
        t_framed_byte r;
        logic [1:0]   m;
        bit           done;
        int           p;
        logic [63:0]  v;
        logic [1:0]   err;
        r      = '0;
        r.data = b;
        r.tag  = TAG_HEADER;
        err    = ERR_NONE;
        if (fr_phase == FR_BODY) begin
            r.tag = TAG_BODY;
            if (body_left != 64'd0) begin
                body_left = body_left - 64'd1;
            end
            if (body_left == 64'd0) begin
                r.fin = 1'b1;
                r.len = up_val[BODY_LEN_W-1:0];
                clear_framer();
            end
        end else begin
            m    = crlf_seen;
            done = 1'b0;
            if (b == CH_CR) begin
                crlf_seen = (m == 2'd2) ? 2'd3 : 2'd1;
            end else if (b == CH_LF && m == 2'd1) begin
                crlf_seen = 2'd2;
            end else if (b == CH_LF && m == 2'd3) begin
                crlf_seen = 2'd0;
                done      = 1'b1;
            end else begin
                crlf_seen = 2'd0;
            end

            if (b == CH_CR || b == CH_LF) begin
                r.tag = TAG_DELIM;
                if (b == CH_LF && m == 2'd1) begin
                    fr_phase = FR_HEADER;
                end
            end else if (fr_phase == FR_METHOD) begin
                r.tag = TAG_METHOD;
                if (b == CH_SP) begin
                    r.tag    = TAG_DELIM;
                    fr_phase = FR_PATH;
                    spaces   = 2'd1;
                end
            end else if (fr_phase == FR_PATH) begin
                r.tag = TAG_PATH;
                if (b == CH_SP) begin
                    r.tag    = TAG_DELIM;
                    fr_phase = FR_VERSION;
                    spaces   = 2'd2;
                end
            end else if (fr_phase == FR_VERSION) begin
                r.tag = TAG_VERSION;
            end

            value_byte(b);
            if (!up_hit) begin
                p = pattern_next(upper_name, up_pos, b);
                if (p == PAT_LEN) begin
                    up_pos = 0;
                    up_hit = 1'b1;
                    begin_value(1'b1);
                end else begin
                    up_pos = p;
                end
            end
            if (!up_hit && !lo_hit) begin
                p = pattern_next(lower_name, lo_pos, b);
                if (p == PAT_LEN) begin
                    lo_pos = 0;
                    lo_hit = 1'b1;
                    begin_value(1'b0);
                end else begin
                    lo_pos = p;
                end
            end

            if (done) begin
                v = 64'd0;
                if (val_state != LV_IDLE) begin
                    finish_value();
                end
                if (up_hit) begin
                    v = up_val;
                end else if (lo_hit) begin
                    v = lo_val;
                end
                if (spaces < 2'd2) begin
                    err = ERR_LINE;
                end else if (v[63]) begin
                    err = ERR_LENGTH;
                end
                clear_framer();
                if (err != ERR_NONE || v == 64'd0) begin
                    r.fin = 1'b1;
                end else begin
                    fr_phase  = FR_BODY;
                    body_left = v;
                    up_val    = v;
                end
            end
        end
        r.err = err;
        return r;
    endfunction

    function automatic t_stim_row known_row(input logic [7:0] d, input logic [2:0] tag,
                                            input logic fin, input logic [1:0] err);
        t_stim_row s;
        s          = '0;
        s.known    = 1'b1;
        s.want.data = d;
        s.want.tag = tag;
        s.want.fin = fin;
        s.want.err = err;
        return s;
    endfunction

    function automatic t_stim_row predicted_row(input logic [7:0] d);
        t_stim_row s;
        s           = '0;
        s.want.data = d;
        return s;
    endfunction

    // request text builders
    function automatic void add_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            req_bytes.push_back(s[i]);
        end
    endfunction

    function automatic void add_crlf();
        req_bytes.push_back(CH_CR);
        req_bytes.push_back(CH_LF);
    endfunction

    function automatic logic [7:0] token_char();
        string punct;
        logic [7:0] c;
        punct = "/.-_?=&%:";
        case ($urandom_range(0, 3))
            0:       c = "a" + 8'($urandom_range(0, 25));
            1:       c = "A" + 8'($urandom_range(0, 25));
            2:       c = CH_ZERO + 8'($urandom_range(0, 9));
            default: c = punct[$urandom_range(0, punct.len() - 1)];
        endcase
        return c;
    endfunction

    function automatic void add_token(input int n);
        repeat (n) req_bytes.push_back(token_char());
    endfunction

    function automatic logic [7:0] noise_byte();
        logic [7:0] c;
        if ($urandom_range(0, 1) == 0) begin
            c = 8'($urandom_range(0, 255));
        end else begin
            case ($urandom_range(0, 7))
                0:       c = CH_CR;
                1:       c = CH_LF;
                2:       c = CH_SP;
                3:       c = CH_MINUS;
                4:       c = ":";
                5:       c = CH_ZERO + 8'($urandom_range(0, 9));
                6:       c = "C";
                default: c = "c";
            endcase
        end
        return c;
    endfunction

    // positive values stay small or overflow to zero, so that bodies stay short
    function automatic void add_length_value();
        repeat ($urandom_range(0, 2)) begin
            req_bytes.push_back(($urandom_range(0, 1) == 0) ? CH_SP : CH_TAB);
        end
        case ($urandom_range(0, 11))
            0, 1, 2, 3, 4: begin
                add_text($sformatf("%0d", $urandom_range(1, 40)));
            end
            5: begin
                if ($urandom_range(0, 1) == 0) begin
                    add_text("0");
                end else begin
                    add_text("000");
                end
            end
            6: begin
                add_text("-0");
            end
            7: begin
                add_text("-");
            end
            8: begin
                add_text($sformatf("-%0d", $urandom_range(1, 99999)));
            end
            9: begin
                case ($urandom_range(0, 3))
                    0:       add_text("-9223372036854775808");
                    1:       add_text("-9223372036854775809");
                    2:       add_text("9223372036854775808");
                    default: add_text("999999999999999999999999");
                endcase
            end
            10: begin
                add_text($sformatf("00%0d", $urandom_range(1, 9)));
            end
            default: begin
            end
        endcase
        if ($urandom_range(0, 3) == 0) begin
            if ($urandom_range(0, 1) == 0) begin
                add_text(" x");
            end else begin
                add_text(";q");
            end
        end
    endfunction

    function automatic void add_length_line();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick <= 5) begin
            add_text(upper_name);
        end else if (pick <= 7) begin
            add_text(lower_name);
        end else if (pick == 8) begin
            add_text(lower_name);
            add_length_value();
            add_crlf();
            add_text(upper_name);
        end else begin
            case ($urandom_range(0, 2))
                0:       add_text("Content-length:");
                1:       add_text("Content-Content-Length:");
                default: add_text("content-Length:");
            endcase
        end
        add_length_value();
        add_crlf();
    endfunction

    function automatic void add_plain_line();
        add_token($urandom_range(1, 6));
        if ($urandom_range(0, 11) == 0) begin
            req_bytes.push_back(($urandom_range(0, 1) == 0) ? CH_CR : CH_LF);
        end
        add_text(": ");
        add_token($urandom_range(0, 8));
        add_crlf();
    endfunction

    function automatic void build_request();
        int kind;
        int spaces_wanted;
        int lines;
        int len_at;
        bit with_len;
        req_bytes.delete();
        kind = $urandom_range(0, 99);
        if (kind < 12) begin
            repeat ($urandom_range(1, 24)) req_bytes.push_back(noise_byte());
        end else begin
            spaces_wanted = (kind < 22) ? $urandom_range(0, 1) : 2;
            repeat ($urandom_range(1, 5)) req_bytes.push_back("A" + 8'($urandom_range(0, 25)));
            if (spaces_wanted >= 1) begin
                req_bytes.push_back(CH_SP);
                req_bytes.push_back("/");
                add_token($urandom_range(0, 6));
            end
            if (spaces_wanted == 2) begin
                req_bytes.push_back(CH_SP);
                if ($urandom_range(0, 3) == 0) begin
                    req_bytes.push_back(CH_SP);
                end
                if ($urandom_range(0, 1) == 0) begin
                    add_text("HTTP/1.1");
                end else begin
                    add_token($urandom_range(0, 4));
                end
            end
            if ($urandom_range(0, 7) == 0) begin
                // no header section at all
                add_crlf();
                add_crlf();
            end else begin
                add_crlf();
                lines    = $urandom_range(0, 3);
                len_at   = $urandom_range(0, lines);
                with_len = ($urandom_range(0, 4) != 0);
                for (int i = 0; i <= lines; i++) begin
                    if (with_len && i == len_at) begin
                        add_length_line();
                    end
                    if (i < lines) begin
                        add_plain_line();
                    end
                end
                add_crlf();
            end
        end
    endfunction

    task automatic send_byte(input logic [7:0] b, input bit has_known,
                             input t_framed_byte known_result);
        t_framed_byte expected;
        int           gap;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(80, 200)
                                                     : $urandom_range(1, 24);
            if (gap != 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_valid     <= 1'b1;
        i_data_byte <= b;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        expected = frame_byte(b);
        if (has_known) begin
            expected = known_result;
        end
        framed_q.push_back(expected);
        bytes_sent++;
    endtask

    task automatic report(input string field, input logic [63:0] want, input logic [63:0] got);
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        mismatches++;
    endtask

    // receiver stall pattern, changes mode when its random window runs out
    always @(posedge i_clk) begin
        if (ready_window == 0) begin
            ready_mode   = $urandom_range(0, 3);
            ready_window = $urandom_range(20, 120);
        end
        ready_window--;
        case (ready_mode)
            0:       i_ready <= 1'b1;
            1:       i_ready <= ~i_ready;
            2:       i_ready <= ($urandom_range(0, 9) >= 3);
            default: i_ready <= ((ready_window % 16) < 5);
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (framed_q.size() == 0) begin
                $display("%0t: result with no item pending, byte %0d", $time, o_byte_out);
                mismatches++;
            end else begin
                checked_item = framed_q.pop_front();
                if (o_byte_out !== checked_item.data) begin
                    report("byte_out", 64'(checked_item.data), 64'(o_byte_out));
                end
                if (o_field_tag !== checked_item.tag) begin
                    report("field_tag", 64'(checked_item.tag), 64'(o_field_tag));
                end
                if (o_message_end !== checked_item.fin) begin
                    report("message_end", 64'(checked_item.fin), 64'(o_message_end));
                end
                if (o_error_code !== checked_item.err) begin
                    report("error_code", 64'(checked_item.err), 64'(o_error_code));
                end
                if (o_body_length !== checked_item.len) begin
                    report("body_length", 64'(checked_item.len), 64'(o_body_length));
                end
                if (checked_item.fin) begin
                    requests_done++;
                    if (checked_item.err == ERR_LINE) begin
                        line_errors++;
                    end else if (checked_item.err == ERR_LENGTH) begin
                        length_errors++;
                    end
                end
                if (checked_item.tag == TAG_BODY) begin
                    body_bytes++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("%0t: timed out with %0d results outstanding", $time, framed_q.size());
            $display("http_request_framer regression: fail");
            $finish;
        end
    end

    initial begin
        clear_framer();
        dir_rows = '{
            // bad request line, extreme byte values
            known_row(8'hff, TAG_METHOD, 1'b0, ERR_NONE),
            known_row(CH_CR, TAG_DELIM, 1'b0, ERR_NONE),
            predicted_row(CH_LF),
            predicted_row(CH_CR),
            known_row(CH_LF, TAG_DELIM, 1'b1, ERR_LINE),
            // stray cr/lf, extra space in version, ends with no length
            predicted_row(CH_SP),
            known_row(8'h00, TAG_PATH, 1'b0, ERR_NONE),
            predicted_row(CH_CR),
            predicted_row(CH_SP),
            predicted_row(CH_SP),
            predicted_row(CH_LF),
            predicted_row(CH_CR),
            predicted_row(CH_LF),
            predicted_row(CH_CR),
            known_row(CH_LF, TAG_DELIM, 1'b1, ERR_NONE),
            // short request with one header line
            predicted_row("a"),
            predicted_row(CH_SP),
            predicted_row("b"),
            predicted_row(CH_SP),
            predicted_row(CH_CR),
            predicted_row(CH_LF),
            predicted_row("h"),
            predicted_row(CH_CR),
            predicted_row(CH_LF),
            predicted_row(CH_CR),
            predicted_row(CH_LF)
        };

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[k]) begin
            send_byte(dir_rows[k].want.data, dir_rows[k].known, dir_rows[k].want);
        end

        while (bytes_sent < DIR_ROWS + RANDOM_ITEMS) begin
            build_request();
            foreach (req_bytes[k]) begin
                send_byte(req_bytes[k], 1'b0, '0);
            end
            while (fr_phase == FR_BODY) begin
                send_byte(8'($urandom_range(0, 255)), 1'b0, '0);
            end
            if (!drained_once && bytes_sent > 500) begin
                // hold off until the framer has handed back everything
                i_valid <= 1'b0;
                while (framed_q.size() != 0) @(posedge i_clk);
                drained_once = 1'b1;
                burst_left   = 0;
            end
        end
        i_valid <= 1'b0;

        while (framed_q.size() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);

        $display("framed %0d bytes over %0d requests, %0d of them body bytes",
                 bytes_sent, requests_done, body_bytes);
        $display("closed with %0d bad request lines and %0d negative lengths, %0d mismatches",
                 line_errors, length_errors, mismatches);
        if (mismatches == 0) begin
            $display("http_request_framer regression: pass");
        end else begin
            $display("http_request_framer regression: fail");
        end
        $finish;
    end

endmodule

/* http_request_framer.f */
hdl/hrf_pkg.sv
hdl/hrf_len_parser.sv
hdl/http_request_framer.sv
sim/http_request_framer_tb.sv
